FILE: rtl/aaq_pkg.sv
package aaq_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int RSQRT_STEPS_DEF = 3;
   localparam int ATAN_LEN = 24;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [31:0] GUESS_BASE_Q30 = 32'd2505397589;
   localparam logic [31:0] THREE_Q30 = 32'd3221225472;
   localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
   localparam logic [17:0] Q14_ONE = 18'd16384;

   // Everything an item needs on its way down the pipeline.
   typedef struct packed {
      logic zero;
      logic neg_cos;
      logic [2:0] neg;
      logic [2:0][15:0] mag;
      logic [2:0][31:0] sq;
      logic [31:0] n;
      logic [4:0] h;
      logic [30:0] n3;
      logic [31:0] r;
      logic [32:0] r2;
      logic [31:0] t;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic [2:0][47:0] ur;
      logic [2:0][31:0] u;
      logic [31:0] sin_mag;
      logic cy_neg;
      logic [16:0] wmag;
      logic w_neg;
      logic [2:0][63:0] prod;
      logic [3:0][15:0] quat;
   } item_type;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0: v = 34'sd843314857;
         5'd1: v = 34'sd497837829;
         5'd2: v = 34'sd263043837;
         5'd3: v = 34'sd133525159;
         5'd4: v = 34'sd67021687;
         5'd5: v = 34'sd33543516;
         5'd6: v = 34'sd16775851;
         5'd7: v = 34'sd8388437;
         5'd8: v = 34'sd4194283;
         5'd9: v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/aaq_rsqrt.sv
// Newton refinement of the reciprocal square root, three stages per step:
// square the estimate, scale by the mantissa and form 3 - m*r^2, multiply back.
module aaq_rsqrt #(
   parameter int RSQRT_STEPS = aaq_pkg::RSQRT_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  aaq_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output aaq_pkg::item_type out_item
);

   localparam int NST = 3 * RSQRT_STEPS;

   aaq_pkg::item_type item_ff [NST];
   logic [NST-1:0] v_ff;
   logic [NST:0] adv;

   assign adv[NST] = out_ready;
   assign in_ready = adv[0];
   assign out_valid = v_ff[NST-1];
   assign out_item = item_ff[NST-1];

   for (genvar j = 0; j < NST; j++) begin : g_st
      aaq_pkg::item_type prev;
      aaq_pkg::item_type nxt_in;
      logic [63:0] prod;
      logic v_src;

      if (j == 0) begin : g_first
         assign prev = in_item;
         assign v_src = in_valid;
      end else begin : g_next
         assign prev = item_ff[j-1];
         assign v_src = v_ff[j-1];
      end

      assign adv[j] = !v_ff[j] || adv[j+1];

      if (j % 3 == 0) begin : g_sq
         assign prod = {32'b0, prev.r} * {32'b0, prev.r};
         always_comb begin
            nxt_in = prev;
            nxt_in.r2 = prod[62:30];
         end
      end else if (j % 3 == 1) begin : g_mr
         logic [32:0] mr2;
         assign prod = {34'b0, prev.n[31:2]} * {31'b0, prev.r2};
         assign mr2 = prod[62:30];
         always_comb begin
            nxt_in = prev;
            if (mr2 >= {1'b0, aaq_pkg::THREE_Q30}) begin
               nxt_in.t = '0;
            end else begin
               nxt_in.t = aaq_pkg::THREE_Q30 - mr2[31:0];
            end
         end
      end else begin : g_upd
         assign prod = {32'b0, prev.r} * {32'b0, prev.t};
         always_comb begin
            nxt_in = prev;
            nxt_in.r = prod[62:31];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            v_ff[j] <= v_src;
         end
         if (adv[j]) begin
            item_ff[j] <= nxt_in;
         end
      end
   end

endmodule

FILE: rtl/aaq_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage.
module aaq_cordic #(
   parameter int CORDIC_STEPS = aaq_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  aaq_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output aaq_pkg::item_type out_item
);

   aaq_pkg::item_type item_ff [CORDIC_STEPS];
   logic [CORDIC_STEPS-1:0] v_ff;
   logic [CORDIC_STEPS:0] adv;

   assign adv[CORDIC_STEPS] = out_ready;
   assign in_ready = adv[0];
   assign out_valid = v_ff[CORDIC_STEPS-1];
   assign out_item = item_ff[CORDIC_STEPS-1];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
      aaq_pkg::item_type prev;
      aaq_pkg::item_type nxt_in;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] ang;
      logic v_src;

      if (i == 0) begin : g_first
         assign prev = in_item;
         assign v_src = in_valid;
      end else begin : g_next
         assign prev = item_ff[i-1];
         assign v_src = v_ff[i-1];
      end

      assign adv[i] = !v_ff[i] || adv[i+1];
      assign dx = prev.cy >>> i;
      assign dy = prev.cx >>> i;
      assign ang = aaq_pkg::atan_q30(5'(i));

      // A residual of exactly zero rotates in the positive direction.
      always_comb begin
         nxt_in = prev;
         if (!prev.cz[33]) begin
            nxt_in.cx = prev.cx - dx;
            nxt_in.cy = prev.cy + dy;
            nxt_in.cz = prev.cz - ang;
         end else begin
            nxt_in.cx = prev.cx + dx;
            nxt_in.cy = prev.cy - dy;
            nxt_in.cz = prev.cz + ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            v_ff[i] <= v_src;
         end
         if (adv[i]) begin
            item_ff[i] <= nxt_in;
         end
      end
   end

endmodule

FILE: rtl/axis_angle_to_quaternion.sv
// Channel   Direction  Ports                                   Handshake
// req       in         req_axis_x/y/z, req_angle               req_valid / req_ready
// rsp       out        rsp_quat_x/y/z/w, rsp_zero_axis         rsp_valid / rsp_ready
//
// The pipeline is made of five front stages, the Newton stages, the CORDIC stages
// and four output stages.
// One item is accepted per cycle while the output side keeps up.
// Each stage moves on when it is empty or its successor moves, so bubbles close up
// and new items keep entering while a finished item waits at the output.
// Synchronous reset clears only the stage valid bits.
module axis_angle_to_quaternion #(
   parameter int CORDIC_STEPS = aaq_pkg::CORDIC_STEPS_DEF,
   parameter int RSQRT_STEPS = aaq_pkg::RSQRT_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [15:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w,
   output logic               rsp_zero_axis
);

   // Stages 0..4 sit in front of the Newton unit, 5..8 after the CORDIC.
   localparam int NLOC = 9;

   aaq_pkg::item_type loc_ff [NLOC];
   aaq_pkg::item_type loc_in [NLOC];
   logic [NLOC-1:0] loc_v_ff;
   logic [NLOC-1:0] loc_src_v;
   logic [NLOC-1:0] loc_adv;
   logic [NLOC-1:0] loc_succ_rdy;

   aaq_pkg::item_type rq_out;
   aaq_pkg::item_type cd_out;
   logic rq_in_ready;
   logic rq_out_valid;
   logic cd_in_ready;
   logic cd_out_valid;

   aaq_rsqrt #(
      .RSQRT_STEPS(RSQRT_STEPS)
   ) u_rsqrt (
      .clock(clock),
      .reset(reset),
      .in_valid(loc_v_ff[4]),
      .in_ready(rq_in_ready),
      .in_item(loc_ff[4]),
      .out_valid(rq_out_valid),
      .out_ready(cd_in_ready),
      .out_item(rq_out)
   );

   aaq_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .in_valid(rq_out_valid),
      .in_ready(cd_in_ready),
      .in_item(rq_out),
      .out_valid(cd_out_valid),
      .out_ready(loc_adv[5]),
      .out_item(cd_out)
   );

   always_comb begin
      for (int k = 0; k < NLOC; k++) begin
         if (k == 4) begin
            loc_succ_rdy[k] = rq_in_ready;
         end else if (k == NLOC - 1) begin
            loc_succ_rdy[k] = rsp_ready;
         end else begin
            loc_succ_rdy[k] = loc_adv[k+1];
         end
      end
   end

   assign loc_adv = ~loc_v_ff | loc_succ_rdy;
   assign loc_src_v = {loc_v_ff[7:5], cd_out_valid, loc_v_ff[3:0], req_valid};
   assign req_ready = loc_adv[0];

   always_comb begin
      logic [15:0] ain [3];
      logic signed [33:0] half;
      logic [31:0] len2;
      logic [3:0] ktop;
      logic [4:0] sh;
      logic [63:0] p3;
      logic signed [33:0] cxs;
      logic [33:0] wabs;
      logic [33:0] ysum;
      logic [63:0] psum;
      logic [17:0] pm;
      logic [17:0] wm;
      ain[0] = req_axis_x;
      ain[1] = req_axis_y;
      ain[2] = req_axis_z;
      half = '0;
      ktop = '0;
      sh = '0;
      p3 = '0;
      cxs = '0;
      wabs = '0;
      ysum = '0;
      psum = '0;
      pm = '0;
      wm = '0;
      len2 = '0;
      for (int k = 0; k < NLOC; k++) begin
         loc_in[k] = loc_ff[k];
      end

      // Stage 0: magnitudes, signs and the half angle folded into +-pi/2.
      loc_in[0] = '0;
      for (int i = 0; i < 3; i++) begin
         loc_in[0].neg[i] = ain[i][15];
         loc_in[0].mag[i] = ain[i][15] ? 16'(-ain[i]) : ain[i];
      end
      half = {req_angle[15], req_angle, 17'b0};
      loc_in[0].cx = aaq_pkg::GAIN_Q30;
      loc_in[0].cy = '0;
      loc_in[0].cz = half;
      if (half > aaq_pkg::HALF_PI_Q30) begin
         loc_in[0].cz = aaq_pkg::PI_Q30 - half;
         loc_in[0].neg_cos = 1'b1;
      end else if (half < -aaq_pkg::HALF_PI_Q30) begin
         loc_in[0].cz = -aaq_pkg::PI_Q30 - half;
         loc_in[0].neg_cos = 1'b1;
      end

      // Stage 1: squares.
      loc_in[1] = loc_ff[0];
      for (int i = 0; i < 3; i++) begin
         loc_in[1].sq[i] = {16'b0, loc_ff[0].mag[i]} * {16'b0, loc_ff[0].mag[i]};
      end

      // Stage 2: length squared, shifted up by pairs of bits into [2^30, 2^32).
      loc_in[2] = loc_ff[1];
      len2 = loc_ff[1].sq[0] + loc_ff[1].sq[1] + loc_ff[1].sq[2];
      for (int k = 0; k < 16; k++) begin
         if (len2[2*k +: 2] != 2'b00) begin
            ktop = 4'(k);
         end
      end
      sh = 5'd30 - {ktop, 1'b0};
      loc_in[2].zero = (len2 == '0);
      loc_in[2].h = {1'b0, ktop} + 5'd1;
      loc_in[2].n = len2 << sh;

      // Stages 3 and 4: initial guess (7 - 4m)/3, with n/3 by reciprocal multiply.
      loc_in[3] = loc_ff[2];
      p3 = {32'b0, loc_ff[2].n} * {32'b0, aaq_pkg::RECIP3};
      loc_in[3].n3 = p3[63:33];
      loc_in[4] = loc_ff[3];
      loc_in[4].r = aaq_pkg::GUESS_BASE_Q30 - {1'b0, loc_ff[3].n3};

      // Stage 5: |axis| * r, |sin|, and the rounded cosine magnitude.
      loc_in[5] = cd_out;
      for (int i = 0; i < 3; i++) begin
         loc_in[5].ur[i] = {32'b0, cd_out.mag[i]} * {16'b0, cd_out.r};
      end
      ysum = cd_out.cy[33] ? 34'(-cd_out.cy) : cd_out.cy;
      loc_in[5].sin_mag = ysum[31:0];
      loc_in[5].cy_neg = cd_out.cy[33];
      cxs = cd_out.neg_cos ? -cd_out.cx : cd_out.cx;
      wabs = cxs[33] ? 34'(-cxs) : cxs;
      wabs = wabs + 34'd32768;
      loc_in[5].wmag = wabs[32:16];
      loc_in[5].w_neg = cxs[33];

      // Stage 6: unit axis components, rounded back to Q.30.
      loc_in[6] = loc_ff[5];
      for (int i = 0; i < 3; i++) begin
         loc_in[6].u[i] = 32'((loc_ff[5].ur[i] + (48'd1 << (loc_ff[5].h - 5'd1)))
                              >> loc_ff[5].h);
      end

      // Stage 7: scale by sin of the half angle.
      loc_in[7] = loc_ff[6];
      for (int i = 0; i < 3; i++) begin
         loc_in[7].prod[i] = {32'b0, loc_ff[6].u[i]} * {32'b0, loc_ff[6].sin_mag};
      end

      // Stage 8: round half away from zero, saturate, apply signs, clear a zero-length axis.
      loc_in[8] = loc_ff[7];
      for (int i = 0; i < 3; i++) begin
         psum = loc_ff[7].prod[i] + 64'h0000_2000_0000_0000;
         pm = psum[63:46];
         if (pm > aaq_pkg::Q14_ONE) begin
            pm = aaq_pkg::Q14_ONE;
         end
         if (loc_ff[7].zero) begin
            loc_in[8].quat[i] = '0;
         end else if (loc_ff[7].neg[i] != loc_ff[7].cy_neg) begin
            loc_in[8].quat[i] = 16'(-pm);
         end else begin
            loc_in[8].quat[i] = pm[15:0];
         end
      end
      wm = {1'b0, loc_ff[7].wmag};
      if (wm > aaq_pkg::Q14_ONE) begin
         wm = aaq_pkg::Q14_ONE;
      end
      if (loc_ff[7].zero) begin
         loc_in[8].quat[3] = '0;
      end else if (loc_ff[7].w_neg) begin
         loc_in[8].quat[3] = 16'(-wm);
      end else begin
         loc_in[8].quat[3] = wm[15:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NLOC; k++) begin
         if (reset) begin
            loc_v_ff[k] <= 1'b0;
         end else if (loc_adv[k]) begin
            loc_v_ff[k] <= loc_src_v[k];
         end
         if (loc_adv[k]) begin
            loc_ff[k] <= loc_in[k];
         end
      end
   end

   assign rsp_valid = loc_v_ff[NLOC-1];
   assign rsp_quat_x = loc_ff[NLOC-1].quat[0];
   assign rsp_quat_y = loc_ff[NLOC-1].quat[1];
   assign rsp_quat_z = loc_ff[NLOC-1].quat[2];
   assign rsp_quat_w = loc_ff[NLOC-1].quat[3];
   assign rsp_zero_axis = loc_ff[NLOC-1].zero;

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_axis |->
         rsp_quat_x == 16'sd0 && rsp_quat_y == 16'sd0 &&
         rsp_quat_z == 16'sd0 && rsp_quat_w == 16'sd0)
      else $error("zero axis item carries nonzero components");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= 16'sd16384 && rsp_quat_w >= -16'sd16384)
      else $error("scalar part outside saturation range");

   a_rst_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      loc_v_ff[4] && !rq_in_ready |=> loc_v_ff[4] && $stable(loc_ff[4].r))
      else $error("item lost at the Newton unit input");

endmodule
